/* rtl/assert_macros.svh */
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/lru_pkg.sv */
`default_nettype none
package lru_pkg;
  localparam int MAX_FRAMES = 16;
  localparam int PAGE_BITS  = 16;
  localparam int FRAME_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int RANK_W     = FRAME_W;
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int CFG_W      = 5;
  localparam int TREE_N     = 1 << FRAME_W;
  localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(16);
  localparam logic [RANK_W-1:0] RANK_MAX  = RANK_W'(MAX_FRAMES - 1);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_CALC
  } state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;
endpackage
`default_nettype wire

/* rtl/lru_page_replacement.sv */
// channel   direction  handshake            payload
// in        input      in_valid/in_stall    page
// out       output     out_valid/out_stall  fault, frame, evicted_valid, evicted_page
// cfg       input      cfg_write            cfg_data (frames_in_use)
//
// per item: the page is registered first, then the parallel match,
// oldest-frame search and rank update run, which also loads the output register
// a new item is accepted while the previous result waits in the output register
// a result stalled on out holds the next item in the update cycle until taken
// rst is synchronous: ranks and fill count clear, frame count returns to 16
`default_nettype none
module lru_page_replacement import lru_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PAGE_BITS-1:0] page,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 fault,
  output logic [FRAME_W-1:0]   frame,
  output logic                 evicted_valid,
  output logic [PAGE_BITS-1:0] evicted_page
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  lru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lru_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .page          (page),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .fault         (fault),
    .frame         (frame),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page)
  );
endmodule
`default_nettype wire

/* rtl/lru_ctrl.sv */
`default_nettype none
module lru_ctrl import lru_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CALC;
      end
      ST_CALC: begin
        if (!stat.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_CALC: begin
        cmd.commit = !stat.out_busy;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end
endmodule
`default_nettype wire

/* rtl/lru_dp.sv */
`default_nettype none
module lru_dp import lru_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic                 cfg_write,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [PAGE_BITS-1:0] page,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 fault,
  output logic [FRAME_W-1:0]   frame,
  output logic                 evicted_valid,
  output logic [PAGE_BITS-1:0] evicted_page
);
  logic [CFG_W-1:0]     frames_in_use;
  logic [PAGE_BITS-1:0] page_q;
  logic [PAGE_BITS-1:0] frame_pages [MAX_FRAMES];
  logic [RANK_W-1:0]    recency_rank [MAX_FRAMES];
  logic [RANK_W-1:0]    rank_next [MAX_FRAMES];
  logic [CNT_W-1:0]     frames_filled;

  logic [CNT_W-1:0]     n_act;
  logic [CNT_W-1:0]     look;
  logic                 hit;
  logic [FRAME_W-1:0]   hit_idx;
  logic                 t_v [1:2*TREE_N-1];
  logic [RANK_W-1:0]    t_r [1:2*TREE_N-1];
  logic [FRAME_W-1:0]   t_i [1:2*TREE_N-1];
  logic                 pick_r;

  logic [FRAME_W-1:0]   f_sel;
  logic [CNT_W-1:0]     limit;
  logic [RANK_W:0]      below;
  logic                 do_fill;
  logic                 do_evict;

  // active frame count, clamped to 1..MAX_FRAMES
  always_comb begin
    if (frames_in_use == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(frames_in_use) > MAX_FRAMES) begin
      n_act = CNT_W'(MAX_FRAMES);
    end else begin
      n_act = CNT_W'(frames_in_use);
    end
    look = (frames_filled < n_act) ? frames_filled : n_act;
  end

  // parallel match, highest index wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if ((i < int'(look)) && (frame_pages[i] == page_q)) begin
        hit     = 1'b1;
        hit_idx = FRAME_W'(i);
      end
    end
  end

  // oldest frame: max rank tree, lowest index on a tie
  always_comb begin
    pick_r = 1'b0;
    for (int i = 0; i < TREE_N; i++) begin
      if (i < MAX_FRAMES) begin
        t_v[TREE_N+i] = (i < int'(n_act));
        t_r[TREE_N+i] = recency_rank[i];
      end else begin
        t_v[TREE_N+i] = 1'b0;
        t_r[TREE_N+i] = '0;
      end
      t_i[TREE_N+i] = FRAME_W'(i);
    end
    for (int k = TREE_N - 1; k >= 1; k--) begin
      pick_r = t_v[2*k+1] && (!t_v[2*k] || (t_r[2*k+1] > t_r[2*k]));
      t_v[k] = t_v[2*k] || t_v[2*k+1];
      t_r[k] = pick_r ? t_r[2*k+1] : t_r[2*k];
      t_i[k] = pick_r ? t_i[2*k+1] : t_i[2*k];
    end
  end

  // decision
  always_comb begin
    do_fill  = 1'b0;
    do_evict = 1'b0;
    if (hit) begin
      f_sel = hit_idx;
      limit = look;
      below = {1'b0, recency_rank[hit_idx]};
    end else if (frames_filled < n_act) begin
      do_fill = 1'b1;
      f_sel   = frames_filled[FRAME_W-1:0];
      limit   = look;
      below   = (RANK_W+1)'(MAX_FRAMES);
    end else begin
      do_evict = 1'b1;
      f_sel    = t_i[1];
      limit    = n_act;
      below    = {1'b0, t_r[1]};
    end
  end

  // rank aging
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (FRAME_W'(i) == f_sel) begin
        rank_next[i] = '0;
      end else if ((i < int'(limit)) && ({1'b0, recency_rank[i]} < below)
                   && (recency_rank[i] < RANK_MAX)) begin
        rank_next[i] = recency_rank[i] + RANK_W'(1);
      end else begin
        rank_next[i] = recency_rank[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= CFG_RESET;
      frames_filled <= '0;
      out_valid     <= 1'b0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        recency_rank[i] <= '0;
      end
    end else begin
      if (cfg_write) frames_in_use <= cfg_data;
      if (cmd.commit) begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
          recency_rank[i] <= rank_next[i];
        end
        if (do_fill) frames_filled <= frames_filled + CNT_W'(1);
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) page_q <= page;
    if (cmd.commit) begin
      if (!hit) frame_pages[f_sel] <= page_q;
      fault         <= !hit;
      frame         <= f_sel;
      evicted_valid <= do_evict;
      evicted_page  <= do_evict ? frame_pages[f_sel] : '0;
    end
  end

  assign stat.out_busy = out_valid && out_stall;
endmodule
`default_nettype wire

/* rtl/lru_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module lru_checker import lru_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 fault,
  input logic [FRAME_W-1:0]   frame,
  input logic                 evicted_valid,
  input logic [PAGE_BITS-1:0] evicted_page
);
  `ASSERT_NOW(a_evict_is_fault, clk, rst, out_valid && evicted_valid, fault)
  `ASSERT_NOW(a_no_evict_zero, clk, rst, out_valid && !evicted_valid, evicted_page == '0)
  `ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && !in_stall, in_stall)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(frame))
endmodule

bind lru_page_replacement lru_checker u_chk (.*);
`default_nettype wire
